// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

    typedef enum logic [1:0] {
        REQ_ENQ = 2'd0,
        REQ_DEQ = 2'd1,
        REQ_CLR = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    // Operation broadcast to every cell of the chain in the same cycle.
    typedef struct packed {
        logic enq;
        logic deq;
        logic clr;
    } cell_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell #(
    parameter int VALUE_WIDTH = 16,
    parameter int PRIO_WIDTH  = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  spq_pkg::cell_ctrl_t     ctrl,
    input  logic [VALUE_WIDTH-1:0]  new_value,
    input  logic [PRIO_WIDTH-1:0]   new_priority,
    input  logic                    left_take,
    input  logic                    left_valid,
    input  logic [VALUE_WIDTH-1:0]  left_value,
    input  logic [PRIO_WIDTH-1:0]   left_priority,
    input  logic                    right_valid,
    input  logic [VALUE_WIDTH-1:0]  right_value,
    input  logic [PRIO_WIDTH-1:0]   right_priority,
    output logic                    take,
    output logic                    cell_valid,
    output logic [VALUE_WIDTH-1:0]  cell_value,
    output logic [PRIO_WIDTH-1:0]   cell_priority,
    output logic                    valid_next,
    output logic [VALUE_WIDTH-1:0]  value_next,
    output logic [PRIO_WIDTH-1:0]   priority_next
);

    logic                   valid_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [PRIO_WIDTH-1:0]  priority_reg;

    // A strict compare keeps a new entry behind all entries of equal priority.
    assign take = !valid_reg || (priority_reg > new_priority);

    always_comb
    begin
        valid_next    = valid_reg;
        value_next    = value_reg;
        priority_next = priority_reg;
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.deq)
        begin
            valid_next    = right_valid;
            value_next    = right_value;
            priority_next = right_priority;
        end
        else if (ctrl.enq && take)
        begin
            if (left_take)
            begin
                valid_next    = left_valid;
                value_next    = left_value;
                priority_next = left_priority;
            end
            else
            begin
                valid_next    = 1'b1;
                value_next    = new_value;
                priority_next = new_priority;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        priority_reg <= priority_next;
    end

    assign cell_valid    = valid_reg;
    assign cell_value    = value_reg;
    assign cell_priority = priority_reg;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Beat contents
// request   req_valid/req_ready    req_type, item_value, item_priority
// response  rsp_valid/rsp_ready    status, is_empty, entry_count, head_value, head_priority
//
// Every cell of the chain decides its next entry from its own compare and its
// neighbors, so all cells update together and one request can be taken per cycle
// when no response is stalled. The response appears in the cycle after its request beat.
// A stalled response register holds off new requests; it is freed by rsp_ready
// in the same cycle. Reset empties the queue; stored payloads are not cleared.
module sorted_priority_queue #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 16,
    parameter int PRIO_WIDTH  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [1:0]                   req_type,
    input  logic [VALUE_WIDTH-1:0]       item_value,
    input  logic [PRIO_WIDTH-1:0]        item_priority,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic [1:0]                   status,
    output logic                         is_empty,
    output logic [$clog2(CAPACITY+1)-1:0] entry_count,
    output logic [VALUE_WIDTH-1:0]       head_value,
    output logic [PRIO_WIDTH-1:0]        head_priority
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                   accept;
    logic                   full;
    logic                   empty;
    spq_pkg::cell_ctrl_t    ctrl;
    spq_pkg::status_t       status_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic                   take_w      [CAPACITY];
    logic                   valid_w     [CAPACITY];
    logic [VALUE_WIDTH-1:0] value_w     [CAPACITY];
    logic [PRIO_WIDTH-1:0]  priority_w  [CAPACITY];
    logic                   valid_nx_w  [CAPACITY];
    logic [VALUE_WIDTH-1:0] value_nx_w  [CAPACITY];
    logic [PRIO_WIDTH-1:0]  priority_nx_w [CAPACITY];

    logic                   rsp_valid_reg;
    spq_pkg::status_t       status_reg;
    logic [CNT_W-1:0]       rsp_count_reg;
    logic [VALUE_WIDTH-1:0] head_value_reg;
    logic [PRIO_WIDTH-1:0]  head_priority_reg;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        ctrl        = '0;
        status_next = spq_pkg::ST_OK;
        count_next  = count_reg;
        case (spq_pkg::req_t'(req_type))
            spq_pkg::REQ_ENQ:
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_OVER;
                end
                else
                begin
                    ctrl.enq   = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            spq_pkg::REQ_DEQ:
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_UNDER;
                end
                else
                begin
                    ctrl.deq   = accept;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            spq_pkg::REQ_CLR:
            begin
                ctrl.clr   = accept;
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                   l_take;
            logic                   l_valid;
            logic [VALUE_WIDTH-1:0] l_value;
            logic [PRIO_WIDTH-1:0]  l_priority;
            logic                   r_valid;
            logic [VALUE_WIDTH-1:0] r_value;
            logic [PRIO_WIDTH-1:0]  r_priority;

            if (gi == 0)
            begin : g_first
                assign l_take     = 1'b0;
                assign l_valid    = 1'b0;
                assign l_value    = '0;
                assign l_priority = '0;
            end
            else
            begin : g_mid_l
                assign l_take     = take_w[gi-1];
                assign l_valid    = valid_w[gi-1];
                assign l_value    = value_w[gi-1];
                assign l_priority = priority_w[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign r_valid    = 1'b0;
                assign r_value    = '0;
                assign r_priority = '0;
            end
            else
            begin : g_mid_r
                assign r_valid    = valid_w[gi+1];
                assign r_value    = value_w[gi+1];
                assign r_priority = priority_w[gi+1];
            end

            spq_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .PRIO_WIDTH  (PRIO_WIDTH)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctrl           (ctrl),
                .new_value      (item_value),
                .new_priority   (item_priority),
                .left_take      (l_take),
                .left_valid     (l_valid),
                .left_value     (l_value),
                .left_priority  (l_priority),
                .right_valid    (r_valid),
                .right_value    (r_value),
                .right_priority (r_priority),
                .take           (take_w[gi]),
                .cell_valid     (valid_w[gi]),
                .cell_value     (value_w[gi]),
                .cell_priority  (priority_w[gi]),
                .valid_next     (valid_nx_w[gi]),
                .value_next     (value_nx_w[gi]),
                .priority_next  (priority_nx_w[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // The head reported is the front cell as it stands after this request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg        <= status_next;
            rsp_count_reg     <= count_next;
            head_value_reg    <= valid_nx_w[0] ? value_nx_w[0] : '0;
            head_priority_reg <= valid_nx_w[0] ? priority_nx_w[0] : '0;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign is_empty      = (rsp_count_reg == '0);
    assign entry_count   = rsp_count_reg;
    assign head_value    = head_value_reg;
    assign head_priority = head_priority_reg;

`ifndef NO_ASSERTIONS
    a_rsp_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
        else $error("request beat produced no response");

    a_count_matches_front: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == !valid_w[0])
        else $error("entry count disagrees with front cell occupancy");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == spq_pkg::ST_OVER) |-> (entry_count == CNT_W'(CAPACITY)))
        else $error("overflow reported while queue not full");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == spq_pkg::ST_UNDER) |-> (is_empty && head_priority == '0))
        else $error("underflow reported on a non-empty queue");
`endif

endmodule

// ===== verif/spq_checker.sv =====
`timescale 1ns / 1ps

module spq_checker #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 16,
    parameter int PRIO_WIDTH  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic [1:0]                    req_type,
    input  logic [VALUE_WIDTH-1:0]        item_value,
    input  logic [PRIO_WIDTH-1:0]         item_priority,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [1:0]                    status,
    input  logic                          is_empty,
    input  logic [$clog2(CAPACITY+1)-1:0] entry_count,
    input  logic [VALUE_WIDTH-1:0]        head_value,
    input  logic [PRIO_WIDTH-1:0]         head_priority,
    output int                            outstanding,
    output int                            fail_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic [1:0]             st;
        logic                   empty;
        logic [CNT_W-1:0]       cnt;
        logic [VALUE_WIDTH-1:0] val;
        logic [PRIO_WIDTH-1:0]  pri;
    } queue_view_t;

    // Shadow copy of the sorted entries, front at index 0.
    logic [VALUE_WIDTH-1:0] shadow_vals [CAPACITY];
    logic [PRIO_WIDTH-1:0]  shadow_pris [CAPACITY];
    int                     shadow_count;

    queue_view_t expected_views [$];

    initial
    begin
        fail_count   = 0;
        outstanding  = 0;
        shadow_count = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic apply_queue_op(input logic [1:0] kind, input logic [VALUE_WIDTH-1:0] v,
                                  input logic [PRIO_WIDTH-1:0] p);
        queue_view_t view;
        int          pos;
        int          i;
        view.st = spq_pkg::ST_OK;
        case (kind)
            spq_pkg::REQ_ENQ:
            begin
                if (shadow_count >= CAPACITY)
                    view.st = spq_pkg::ST_OVER;
                else
                begin
                    // Equal priorities stay in arrival order, so skip past them.
                    pos = 0;
                    while (pos < shadow_count && shadow_pris[pos] <= p)
                        pos++;
                    for (i = shadow_count; i > pos; i--)
                    begin
                        shadow_vals[i] = shadow_vals[i-1];
                        shadow_pris[i] = shadow_pris[i-1];
                    end
                    shadow_vals[pos] = v;
                    shadow_pris[pos] = p;
                    shadow_count++;
                end
            end
            spq_pkg::REQ_DEQ:
            begin
                if (shadow_count == 0)
                    view.st = spq_pkg::ST_UNDER;
                else
                begin
                    for (i = 1; i < shadow_count; i++)
                    begin
                        shadow_vals[i-1] = shadow_vals[i];
                        shadow_pris[i-1] = shadow_pris[i];
                    end
                    shadow_count--;
                end
            end
            spq_pkg::REQ_CLR:
                shadow_count = 0;
            default:
                ;
        endcase
        view.empty = (shadow_count == 0);
        view.cnt   = CNT_W'(shadow_count);
        view.val   = (shadow_count != 0) ? shadow_vals[0] : '0;
        view.pri   = (shadow_count != 0) ? shadow_pris[0] : '0;
        expected_views.push_back(view);
    endtask

    task automatic check_response();
        queue_view_t want;
        if (expected_views.size() == 0)
        begin
            report_mismatch("response beat with no pending request", 32'(status), 0);
            return;
        end
        want = expected_views.pop_front();
        if (status !== want.st)
            report_mismatch("status", 32'(status), 32'(want.st));
        if (is_empty !== want.empty)
            report_mismatch("is_empty", 32'(is_empty), 32'(want.empty));
        if (entry_count !== want.cnt)
            report_mismatch("entry_count", 32'(entry_count), 32'(want.cnt));
        if (head_value !== want.val)
            report_mismatch("head_value", 32'(head_value), 32'(want.val));
        if (head_priority !== want.pri)
            report_mismatch("head_priority", 32'(head_priority), 32'(want.pri));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count = 0;
            expected_views.delete();
        end
        else
        begin
            // A response beat always belongs to an earlier request beat.
            if (rsp_valid && rsp_ready)
                check_response();
            if (req_valid && req_ready)
                apply_queue_op(req_type, item_value, item_priority);
        end
        outstanding = expected_views.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int PRIO_WIDTH  = 16;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int RANDOM_ITEMS = 800;
    localparam int CALM_ITEMS   = 100;
    localparam int LONG_HOLD    = 80;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_ready;
    logic [1:0]             req_type;
    logic [VALUE_WIDTH-1:0] item_value;
    logic [PRIO_WIDTH-1:0]  item_priority;
    logic                   rsp_valid;
    logic                   rsp_ready;
    logic [1:0]             status;
    logic                   is_empty;
    logic [CNT_W-1:0]       entry_count;
    logic [VALUE_WIDTH-1:0] head_value;
    logic [PRIO_WIDTH-1:0]  head_priority;
    int                     outstanding;
    int                     fail_count;

    bit calm;
    bit hold_rsp;

    sorted_priority_queue #(
        .CAPACITY(CAPACITY),
        .VALUE_WIDTH(VALUE_WIDTH),
        .PRIO_WIDTH(PRIO_WIDTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_type(req_type),
        .item_value(item_value),
        .item_priority(item_priority),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .status(status),
        .is_empty(is_empty),
        .entry_count(entry_count),
        .head_value(head_value),
        .head_priority(head_priority)
    );

    spq_checker #(
        .CAPACITY(CAPACITY),
        .VALUE_WIDTH(VALUE_WIDTH),
        .PRIO_WIDTH(PRIO_WIDTH)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_type(req_type),
        .item_value(item_value),
        .item_priority(item_priority),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .status(status),
        .is_empty(is_empty),
        .entry_count(entry_count),
        .head_value(head_value),
        .head_priority(head_priority),
        .outstanding(outstanding),
        .fail_count(fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("tb NOT OK");
        $finish;
    end

    // Response side: random stall bursts, one long hold-off that backs up the queue.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                hold_rsp = 1'b0;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                rsp_ready <= 1'b1;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [VALUE_WIDTH-1:0] v,
                                input logic [PRIO_WIDTH-1:0] p);
        req_valid     <= 1'b1;
        req_type      <= kind;
        item_value    <= v;
        item_priority <= p;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_random_request(input bit filling);
        logic [1:0]            kind;
        logic [PRIO_WIDTH-1:0] p;
        int                    roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            kind = REQ_UNUSED;
        else if (roll < 6)
            kind = spq_pkg::REQ_CLR;
        else if (roll < (filling ? 80 : 40))
            kind = spq_pkg::REQ_ENQ;
        else
            kind = spq_pkg::REQ_DEQ;
        // A narrow priority range half of the time produces plenty of ties.
        if ($urandom_range(0, 1) == 0)
            p = PRIO_WIDTH'($urandom_range(0, 7));
        else
            p = PRIO_WIDTH'($urandom());
        send_request(kind, VALUE_WIDTH'($urandom()), p);
    endtask

    initial
    begin
        int  i;
        bit  filling;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_type      = spq_pkg::REQ_ENQ;
        item_value    = '0;
        item_priority = '0;
        calm          = 1'b0;
        hold_rsp      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Corner cases on an empty queue first.
        send_request(spq_pkg::REQ_DEQ, 16'hFFFF, 16'hFFFF);
        send_request(REQ_UNUSED, 16'h0000, 16'h0000);
        send_request(spq_pkg::REQ_CLR, 16'hA5A5, 16'h5A5A);
        send_request(spq_pkg::REQ_ENQ, 16'hFFFF, 16'hFFFF);
        send_request(spq_pkg::REQ_ENQ, 16'h0000, 16'h0000);
        // Fill to capacity with repeated priorities to exercise arrival order.
        for (i = 0; i < CAPACITY - 2; i++)
            send_request(spq_pkg::REQ_ENQ, VALUE_WIDTH'(16'h0100 + i),
                         PRIO_WIDTH'((i % 4) * 16'h5555));
        send_request(spq_pkg::REQ_ENQ, 16'h1234, 16'h0000);
        send_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
        send_request(spq_pkg::REQ_DEQ, 16'h0000, 16'h0000);
        send_request(spq_pkg::REQ_CLR, 16'h0000, 16'h0000);
        send_request(spq_pkg::REQ_DEQ, 16'h0000, 16'h0000);

        hold_rsp = 1'b1;
        filling  = 1'b1;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Alternate between fill-heavy and drain-heavy stretches.
            if (i % 50 == 0)
                filling = (i % 100 == 0);
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            send_random_request(filling);
        end
        req_valid <= 1'b0;

        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
verif/spq_checker.sv
verif/tb.sv
